// ----- rtl/smoothstep_fade_envelope_assert.svh -----
// Assertion macros for the fade envelope block
`ifndef SMOOTHSTEP_FADE_ENVELOPE_ASSERT_SVH
`define SMOOTHSTEP_FADE_ENVELOPE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fade envelope check failed");

// next-cycle implication, checked out of reset
`define SFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fade envelope check failed");

`endif

// ----- rtl/sfe_pkg.sv -----
// Command and fade state codes for the fade envelope block
package sfe_pkg;

	typedef logic [1:0] func_t;
	typedef logic [1:0] fade_state_t;

	localparam func_t FUNC_TICK   = 2'd0;
	localparam func_t FUNC_IN     = 2'd1;
	localparam func_t FUNC_OUT    = 2'd2;
	localparam func_t FUNC_XFADE  = 2'd3;

	localparam fade_state_t FS_IDLE = 2'd0;
	localparam fade_state_t FS_IN   = 2'd1;
	localparam fade_state_t FS_OUT  = 2'd2;

endpackage

// ----- rtl/smoothstep_fade_envelope.sv -----
// Fade envelope generator: bit-serial ramp divider, shared serial multiplier for smoothstep
//
// One word in gives one word out. Fade in, fade out and cross-fade commands, and a tick
// while idle, go from acceptance straight to the done state, where the result is loaded
// into the output register once that register is free. A tick while fading passes through
// a prep state, then the divider and, with smoothstep easing, the multiplier, then a finish
// state and the done state. The restoring divider retires one quotient bit a cycle, and the
// shift-add multiplier, used twice for t*t and a*(3-2t) with smoothstep easing, takes
// one multiplier bit a cycle. A tick that reaches the end of the ramp skips both units. One
// word is worked on at a time; the next is taken while the previous result waits in the
// output register. progress is unsigned with FRACTION_BITS fraction bits, 1.0 = fully on.
`include "smoothstep_fade_envelope_assert.svh"

module smoothstep_fade_envelope
	import sfe_pkg::*;
#(
	parameter int TIME_BITS     = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               func,
	input  logic [TIME_BITS-1:0]     amount,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [FRACTION_BITS:0]   progress,
	output logic [1:0]               fade_state,
	output logic                     pending_source,
	output logic                     swapped
);

	localparam int ONE_W = FRACTION_BITS + 1;
	localparam int MPR_W = FRACTION_BITS + 2;
	localparam int ACC_W = 2 * FRACTION_BITS + 2;
	localparam int CNT_W = $clog2(MPR_W + 1);
	localparam logic [ONE_W-1:0]     ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
	localparam logic [MPR_W-1:0]     THREE_ONE = {2'b11, {FRACTION_BITS{1'b0}}};

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MUL1 = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]               seq_q;
	logic                     smooth_q;
	fade_state_t              mode_q;
	logic [TIME_BITS-1:0]     elapsed_q;
	logic [TIME_BITS-1:0]     span_q;
	logic [ONE_W-1:0]         weight_q;
	logic                     pending_q;
	logic                     swapped_q;
	logic                     out_valid_q;

	logic [TIME_BITS:0]       rem_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [FRACTION_BITS-1:0] mcand_q;
	logic [MPR_W-1:0]         mpr_q;
	logic [ACC_W-1:0]         acc_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [ONE_W-1:0]         s_q;
	logic                     t_full_q;

	logic [ONE_W-1:0]         progress_q;
	fade_state_t              fade_state_q;
	logic                     pending_out_q;
	logic                     swapped_out_q;

	logic                     in_acc;
	logic                     out_load;
	logic [TIME_BITS:0]       sum;
	logic [TIME_BITS:0]       rem_sh;
	logic                     rem_ge;
	logic [TIME_BITS:0]       rem_nxt;
	logic [FRACTION_BITS-1:0] quo_nxt;
	logic [ACC_W-1:0]         acc_nxt;
	logic [ONE_W-1:0]         s_val;

	assign in_ready = (seq_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (seq_q == S_DONE) && (!out_valid_q || out_ready);

	assign sum     = {1'b0, elapsed_q} + {1'b0, amount};
	assign rem_sh  = {rem_q[TIME_BITS-1:0], 1'b0};
	assign rem_ge  = (rem_sh >= {1'b0, span_q});
	assign rem_nxt = rem_ge ? (rem_sh - {1'b0, span_q}) : rem_sh;
	assign quo_nxt = {quo_q[FRACTION_BITS-2:0], rem_ge};

	// MSB-first shift-add
	assign acc_nxt = {acc_q[ACC_W-2:0], 1'b0}
		+ (mpr_q[MPR_W-1] ? {{(ACC_W-FRACTION_BITS){1'b0}}, mcand_q} : {ACC_W{1'b0}});

	always_comb begin
		if (t_full_q) begin
			s_val = ONE;
		end else if (smooth_q) begin
			s_val = s_q;
		end else begin
			s_val = {1'b0, quo_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_IDLE;
			smooth_q    <= 1'b1;
			mode_q      <= FS_IDLE;
			elapsed_q   <= '0;
			span_q      <= '0;
			weight_q    <= '0;
			pending_q   <= 1'b0;
			swapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				smooth_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				S_IDLE: begin
					if (in_acc) begin
						swapped_q <= 1'b0;
						seq_q     <= S_DONE;
						case (func)
							FUNC_IN: begin
								mode_q    <= FS_IN;
								span_q    <= amount;
								elapsed_q <= '0;
								weight_q  <= '0;
							end
							FUNC_OUT: begin
								mode_q    <= FS_OUT;
								span_q    <= amount;
								elapsed_q <= '0;
								weight_q  <= ONE;
							end
							FUNC_XFADE: begin
								pending_q <= 1'b1;
								mode_q    <= FS_OUT;
								span_q    <= amount;
								elapsed_q <= '0;
							end
							default: begin
								if (mode_q == FS_IN || mode_q == FS_OUT) begin
									elapsed_q <= sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
									seq_q     <= S_PREP;
								end
							end
						endcase
					end
				end
				S_PREP: begin
					seq_q <= (elapsed_q >= span_q) ? S_FIN : S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(FRACTION_BITS - 1)) begin
						seq_q <= smooth_q ? S_MUL1 : S_FIN;
					end
				end
				S_MUL1: begin
					if (cnt_q == CNT_W'(MPR_W - 1)) begin
						seq_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (cnt_q == CNT_W'(MPR_W - 1)) begin
						seq_q <= S_FIN;
					end
				end
				S_FIN: begin
					seq_q <= S_DONE;
					if (mode_q == FS_IN) begin
						weight_q <= s_val;
						if (t_full_q) begin
							mode_q <= FS_IDLE;
						end
					end else if (t_full_q) begin
						if (pending_q) begin
							pending_q <= 1'b0;
							weight_q  <= ONE;
							mode_q    <= FS_IN;
							elapsed_q <= '0;
							swapped_q <= 1'b1;
						end else begin
							weight_q <= '0;
							mode_q   <= FS_IDLE;
						end
					end else begin
						weight_q <= ONE - s_val;
					end
				end
				S_DONE: begin
					if (out_load) begin
						seq_q <= S_IDLE;
					end
				end
				default: begin
					seq_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, loaded before use
	always_ff @(posedge clk) begin
		if (out_load) begin
			progress_q    <= weight_q;
			fade_state_q  <= mode_q;
			pending_out_q <= pending_q;
			swapped_out_q <= swapped_q;
		end
		case (seq_q)
			S_PREP: begin
				t_full_q <= (elapsed_q >= span_q);
				rem_q    <= {1'b0, elapsed_q};
				quo_q    <= '0;
				cnt_q    <= '0;
			end
			S_DIV: begin
				rem_q <= rem_nxt;
				quo_q <= quo_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRACTION_BITS - 1)) begin
					mcand_q <= quo_nxt;
					mpr_q   <= {2'b00, quo_nxt};
					acc_q   <= '0;
					cnt_q   <= '0;
				end
			end
			S_MUL1: begin
				acc_q <= acc_nxt;
				mpr_q <= {mpr_q[MPR_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MPR_W - 1)) begin
					// a = t*t >> F, then multiply by 3 - 2t
					mcand_q <= acc_nxt[FRACTION_BITS +: FRACTION_BITS];
					mpr_q   <= THREE_ONE - {1'b0, quo_q, 1'b0};
					acc_q   <= '0;
					cnt_q   <= '0;
				end
			end
			S_MUL2: begin
				acc_q <= acc_nxt;
				mpr_q <= {mpr_q[MPR_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MPR_W - 1)) begin
					s_q <= acc_nxt[FRACTION_BITS +: ONE_W];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign progress       = progress_q;
	assign fade_state     = fade_state_q;
	assign pending_source = pending_out_q;
	assign swapped        = swapped_out_q;

	`SFE_ASSERT_NEXT(a_busy_after_accept, in_acc, seq_q != S_IDLE)
	`SFE_ASSERT_IMP(a_weight_in_range, 1'b1, weight_q <= ONE)
	`SFE_ASSERT_IMP(a_div_rem_below_span, seq_q == S_DIV, rem_q < {1'b0, span_q})
	`SFE_ASSERT_IMP(a_swap_starts_fade_in, out_valid_q && swapped_out_q, fade_state_q == FS_IN && !pending_out_q)

endmodule
